>>> hdl/bfm2_pkg.sv
// package for the bloom filter with seeded murmur2 hashing
// holds sizes, hash constants, register addresses and the word types
// no dependencies
`default_nettype none
package bfm2_pkg;

    localparam int MAX_CELLS   = 65536;
    localparam int MAX_HASHES  = 8;
    localparam int HASH_W      = $clog2(MAX_HASHES);
    localparam int CELL_W      = $clog2(MAX_CELLS);
    localparam int RAM_W       = 32;
    localparam int RAM_DEPTH   = MAX_CELLS / RAM_W;
    localparam int RAM_AW      = $clog2(RAM_DEPTH);
    localparam int BIT_W       = $clog2(RAM_W);
    localparam int CNT_W       = CELL_W + 1;
    localparam int HCNT_W      = 4;
    localparam int PADDR_W     = 3;

    localparam logic [31:0] MIX_MUL = 32'h5bd1e995;
    localparam int SH_KEY  = 24;
    localparam int SH_FIN1 = 13;
    localparam int SH_FIN2 = 15;

    localparam logic [CNT_W-1:0]  CELL_RESET = CNT_W'(MAX_CELLS);
    localparam logic [HCNT_W-1:0] HASH_RESET = HCNT_W'(4);

    // register index, taken from paddr bit 2
    localparam logic REG_CELL_COUNT = 1'b0;
    localparam logic REG_HASH_COUNT = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [31:0] key_word;
        logic [2:0]  valid_bytes;
        logic [7:0]  key_length;
        logic        last;
    } t_in_word;

    typedef struct packed {
        logic was_query;
        logic present;
    } t_res_word;

endpackage
`default_nettype wire

>>> hdl/bloom_filter_murmur2.sv
// Bloom filter over a 65536-bit store with seeded murmur2 hashes. Keys arrive
// as 32-bit words; a word is accepted when start is high and busy is low. Full
// and short words are mixed into every hash through one shared 32x32
// multiplier; a zero-byte word leaves the hashes as they are. A last word then
// runs, per hash, a multiply step, a bit-serial modulo, a store read and, for
// an insert, a store update. The result strobe o_res_valid is high for one cycle
// and cannot be held off. After reset the store is cleared one 32-bit row a
// cycle, with busy high.
// depends on bfm2_pkg and bfm2_ram
`default_nettype none
module bloom_filter_murmur2
    import bfm2_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire t_in_word           i_in,
    output logic                    o_res_valid,
    output t_res_word               o_res,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);

    typedef enum logic [10:0] {
        S_CLR  = 11'b000_0000_0001,
        S_IDLE = 11'b000_0000_0010,
        S_K1   = 11'b000_0000_0100,
        S_K2   = 11'b000_0000_1000,
        S_HMUL = 11'b000_0001_0000,
        S_HWB  = 11'b000_0010_0000,
        S_F1   = 11'b000_0100_0000,
        S_F2   = 11'b000_1000_0000,
        S_DIV  = 11'b001_0000_0000,
        S_RD   = 11'b010_0000_0000,
        S_CHK  = 11'b100_0000_0000
    } t_state;

    t_state              r_state, n_state;
    logic [RAM_AW-1:0]   r_clr_addr;
    logic [CNT_W-1:0]    r_cell_count;
    logic [HCNT_W-1:0]   r_hash_count;
    logic [31:0]         r_h [MAX_HASHES];
    logic                r_started;
    logic [31:0]         r_word;
    logic [2:0]          r_nb;
    logic                r_last;
    logic                r_kind;
    logic [31:0]         r_prod;
    logic [31:0]         r_k;
    logic [HASH_W-1:0]   r_i;
    logic [HCNT_W-1:0]   r_j;
    logic [31:0]         r_div;
    logic [CELL_W-1:0]   r_rem;
    logic [4:0]          r_cnt;
    logic                r_all;
    logic                r_res_valid;
    t_res_word           r_res;

    logic                accept;
    logic [2:0]          nb_in;
    logic [CNT_W-1:0]    m_eff;
    logic [HCNT_W-1:0]   k_eff;
    logic [31:0]         tail;
    logic [31:0]         h_cur;
    logic [31:0]         h_fin;
    logic [31:0]         mul_a;
    logic [63:0]         mul_full;
    logic [31:0]         prod;
    logic [CNT_W-1:0]    trial;
    logic                ram_we;
    logic [RAM_AW-1:0]   ram_waddr;
    logic [RAM_W-1:0]    ram_wdata;
    logic [RAM_W-1:0]    ram_rdata;
    logic                bit_set;
    logic                cfg_we;

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign pready      = 1'b1;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
    assign cfg_we      = psel && penable && pwrite;

    assign nb_in = (i_in.valid_bytes > 3'd4) ? 3'd4 : i_in.valid_bytes;
    assign m_eff = (r_cell_count == '0) ? CNT_W'(1)
                 : (r_cell_count > CNT_W'(MAX_CELLS)) ? CNT_W'(MAX_CELLS) : r_cell_count;
    assign k_eff = (r_hash_count > HCNT_W'(MAX_HASHES)) ? HCNT_W'(MAX_HASHES)
                 : r_hash_count;

    always_comb begin
        case (r_nb)
            3'd1:    tail = {24'd0, r_word[7:0]};
            3'd2:    tail = {16'd0, r_word[15:0]};
            3'd3:    tail = {8'd0, r_word[23:0]};
            default: tail = r_word;
        endcase
    end

    assign h_cur = r_h[r_i];
    assign h_fin = r_h[r_j[HASH_W-1:0]];

    // shared multiplier, low half only
    always_comb begin
        case (r_state)
            S_K1:    mul_a = r_word;
            S_K2:    mul_a = r_prod ^ (r_prod >> SH_KEY);
            S_HMUL:  mul_a = (r_nb == 3'd4) ? h_cur : (h_cur ^ tail);
            default: mul_a = h_fin ^ (h_fin >> SH_FIN1);
        endcase
    end
    assign mul_full = mul_a * MIX_MUL;
    assign prod     = mul_full[31:0];

    assign trial   = {r_rem, r_div[31]};
    assign bit_set = ram_rdata[r_rem[BIT_W-1:0]];

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_rem[CELL_W-1:BIT_W];
        ram_wdata = ram_rdata | (RAM_W'(1) << r_rem[BIT_W-1:0]);
        if (r_state == S_CLR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else if (r_state == S_CHK && !r_kind) begin
            ram_we = 1'b1;
        end
    end

    bfm2_ram #(
        .WIDTH (RAM_W),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rem[CELL_W-1:BIT_W]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        prdata = (paddr[2] == REG_HASH_COUNT) ? {28'd0, r_hash_count}
                                              : {15'd0, r_cell_count};
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR:  if (r_clr_addr == '1) n_state = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    if (nb_in == 3'd4)       n_state = S_K1;
                    else if (nb_in != 3'd0)  n_state = S_HMUL;
                    else if (i_in.last && k_eff != '0) n_state = S_F1;
                end
            end
            S_K1:   n_state = S_K2;
            S_K2:   n_state = S_HMUL;
            S_HMUL: n_state = S_HWB;
            S_HWB: begin
                if (r_i == HASH_W'(MAX_HASHES - 1)) begin
                    n_state = (r_last && k_eff != '0) ? S_F1 : S_IDLE;
                end else begin
                    n_state = S_HMUL;
                end
            end
            S_F1:   n_state = S_F2;
            S_F2:   n_state = S_DIV;
            S_DIV:  if (r_cnt == 5'd31) n_state = S_RD;
            S_RD:   n_state = S_CHK;
            S_CHK:  n_state = (r_j + HCNT_W'(1) == k_eff) ? S_IDLE : S_F1;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_clr_addr   <= '0;
            r_cell_count <= CELL_RESET;
            r_hash_count <= HASH_RESET;
            r_started    <= 1'b0;
            r_res_valid  <= 1'b0;
            r_i          <= '0;
            r_j          <= '0;
            r_cnt        <= '0;
            for (int i = 0; i < MAX_HASHES; i++) begin
                r_h[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_res_valid <= 1'b0;
            r_prod      <= prod;

            if (cfg_we) begin
                if (paddr[2] == REG_CELL_COUNT) r_cell_count <= pwdata[CNT_W-1:0];
                else                            r_hash_count <= pwdata[HCNT_W-1:0];
            end

            case (r_state)
                S_CLR: r_clr_addr <= r_clr_addr + RAM_AW'(1);
                S_IDLE: begin
                    if (accept) begin
                        r_word <= i_in.key_word;
                        r_nb   <= nb_in;
                        r_last <= i_in.last;
                        r_kind <= i_in.kind;
                        r_i    <= '0;
                        r_j    <= '0;
                        r_all  <= 1'b1;
                        if (!r_started) begin
                            for (int i = 0; i < MAX_HASHES; i++) begin
                                r_h[i] <= 32'(i) ^ {24'd0, i_in.key_length};
                            end
                        end
                        r_started <= !i_in.last;
                        // zero-byte last word with no hashes finishes here
                        if (nb_in == 3'd0 && i_in.last && k_eff == '0) begin
                            r_res_valid     <= 1'b1;
                            r_res.was_query <= i_in.kind;
                            r_res.present   <= i_in.kind;
                        end
                    end
                end
                S_K2: r_k <= prod;
                S_HWB: begin
                    r_h[r_i] <= (r_nb == 3'd4) ? (r_prod ^ r_k) : r_prod;
                    r_i      <= r_i + HASH_W'(1);
                    if (r_i == HASH_W'(MAX_HASHES - 1) && r_last && k_eff == '0) begin
                        r_res_valid     <= 1'b1;
                        r_res.was_query <= r_kind;
                        r_res.present   <= r_kind;
                    end
                end
                S_F2: begin
                    r_div <= r_prod ^ (r_prod >> SH_FIN2);
                    r_rem <= '0;
                    r_cnt <= '0;
                end
                S_DIV: begin
                    // restoring modulo, one dividend bit a cycle
                    if (trial >= m_eff) r_rem <= CELL_W'(trial - m_eff);
                    else                r_rem <= trial[CELL_W-1:0];
                    r_div <= {r_div[30:0], 1'b0};
                    r_cnt <= r_cnt + 5'd1;
                end
                S_CHK: begin
                    if (r_kind && !bit_set) r_all <= 1'b0;
                    r_j <= r_j + HCNT_W'(1);
                    if (r_j + HCNT_W'(1) == k_eff) begin
                        r_res_valid     <= 1'b1;
                        r_res.was_query <= r_kind;
                        r_res.present   <= r_kind && r_all && bit_set;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> hdl/bfm2_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module bfm2_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> tb/sv/bfm2_checker.sv
// checker for bloom_filter_murmur2: watches the word, result and register ports,
// keeps its own copy of the hashes, filter store and registers, and compares results
// depends on bfm2_pkg
module bfm2_checker
    import bfm2_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire t_in_word           i_in,
    input  wire logic               o_res_valid,
    input  wire t_res_word          o_res,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic               pready,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output int                      o_errors,
    output int                      o_pending,
    output int                      o_results,
    output int                      o_hits
);

    logic [16:0] cells_cfg;
    logic [3:0]  hashes_cfg;
    logic [31:0] running_hash [MAX_HASHES];
    logic        key_open;
    bit          filter_store [MAX_CELLS];
    t_res_word   answers_due [$];

    task automatic report(input string what, input logic want, input logic got);
        $display("mismatch on %s: expected %0d got %0d at %0t", what, want, got, $time);
        o_errors++;
    endtask

    function automatic logic [31:0] fold(input logic [31:0] h);
        logic [31:0] x;
        x = h ^ (h >> SH_FIN1);
        x = x * MIX_MUL;
        return x ^ (x >> SH_FIN2);
    endfunction

    // absorb one word into every running hash; on the last word update or look up the store
    task automatic absorb_word(input t_in_word w);
        logic [2:0]  nb;
        logic [31:0] k;
        logic [31:0] t;
        logic [16:0] m;
        int          kk;
        int          idx;
        logic        all_set;
        t_res_word   r;
        nb = (w.valid_bytes > 4) ? 3'd4 : w.valid_bytes;
        if (!key_open) begin
            for (int i = 0; i < MAX_HASHES; i++) running_hash[i] = 32'(i) ^ 32'(w.key_length);
            key_open = 1'b1;
        end
        if (nb == 4) begin
            k = w.key_word * MIX_MUL;
            k = k ^ (k >> SH_KEY);
            k = k * MIX_MUL;
            for (int i = 0; i < MAX_HASHES; i++) running_hash[i] = (running_hash[i] * MIX_MUL) ^ k;
        end else if (nb != 0) begin
            // short word mixed in the tail manner even when not last
            t = w.key_word & ((nb == 3) ? 32'hffffff : (nb == 2) ? 32'hffff : 32'hff);
            for (int i = 0; i < MAX_HASHES; i++) running_hash[i] = (running_hash[i] ^ t) * MIX_MUL;
        end
        if (w.last) begin
            m  = (cells_cfg == 0) ? 17'd1 : (cells_cfg > MAX_CELLS) ? 17'(MAX_CELLS) : cells_cfg;
            kk = (hashes_cfg > MAX_HASHES) ? MAX_HASHES : int'(hashes_cfg);
            all_set = 1'b1;
            for (int i = 0; i < kk; i++) begin
                idx = int'(fold(running_hash[i]) % 32'(m));
                if (!w.kind) filter_store[idx] = 1'b1;
                else if (!filter_store[idx]) all_set = 1'b0;
            end
            r.was_query = w.kind;
            r.present   = w.kind & all_set;
            answers_due.push_back(r);
            key_open = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        t_res_word want;
        if (!i_rst_n) begin
            cells_cfg  = CELL_RESET;
            hashes_cfg = HASH_RESET;
            key_open   = 1'b0;
            foreach (filter_store[i]) filter_store[i] = 1'b0;
            answers_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_CELL_COUNT) cells_cfg = pwdata[16:0];
                else hashes_cfg = pwdata[3:0];
            end
            if (start && !busy) absorb_word(i_in);
            if (o_res_valid) begin
                o_results++;
                if (answers_due.size() == 0) begin
                    report("unexpected result strobe", 1'b0, 1'b1);
                end else begin
                    want = answers_due.pop_front();
                    if (want.present) o_hits++;
                    if (o_res.was_query !== want.was_query)
                        report("was_query", want.was_query, o_res.was_query);
                    if (o_res.present !== want.present)
                        report("present", want.present, o_res.present);
                end
            end
        end
        o_pending = answers_due.size();
    end

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_results = 0;
        o_hits    = 0;
    end

endmodule

>>> tb/sv/bloom_filter_murmur2_tb.sv
// testbench top for bloom_filter_murmur2: drives keys and register writes,
// bfm2_checker predicts and compares; depends on bfm2_pkg and bfm2_checker
module bloom_filter_murmur2_tb;
    import bfm2_pkg::*;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;
    localparam int   DRAIN       = 400;
    localparam int   CYCLE_LIMIT = 3000000;

    typedef struct {
        int          len;
        logic [31:0] w [64];
    } t_key;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    t_in_word           i_in;
    logic               o_res_valid;
    t_res_word          o_res;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    int                 errors;
    int                 pending;
    int                 results;
    int                 hits;
    int                 words_sent;
    int                 idle_pct;
    int                 cycles;
    t_key               key_pool [16];

    bloom_filter_murmur2 uut (.*);

    bfm2_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_in(i_in),
        .o_res_valid(o_res_valid), .o_res(o_res), .psel(psel), .penable(penable),
        .pwrite(pwrite), .pready(pready), .paddr(paddr), .pwdata(pwdata),
        .o_errors(errors), .o_pending(pending), .o_results(results), .o_hits(hits)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // start stays high across back-to-back words, lowered only when idling
    task automatic send_word(input t_in_word w);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        i_in  <= w;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        words_sent++;
    endtask

    task automatic send_key(input t_key key, input logic kind);
        t_in_word w;
        int       nw;
        nw = (key.len == 0) ? 1 : (key.len + 3) / 4;
        for (int j = 0; j < nw; j++) begin
            w.last        = (j == nw - 1);
            w.kind        = w.last ? kind : 1'($urandom);
            w.key_word    = key.w[j];
            w.valid_bytes = w.last ? 3'(key.len - 4 * j) : 3'd4;
            w.key_length  = 8'(key.len);
            send_word(w);
        end
    endtask

    task automatic reg_write(input logic idx, input logic [31:0] value);
        start   <= 1'b0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // registers move only once the block has drained
    task automatic settle_and_configure(input logic [31:0] cells, input logic [31:0] hashes);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        reg_write(REG_CELL_COUNT, cells);
        reg_write(REG_HASH_COUNT, hashes);
    endtask

    function automatic t_key random_key();
        t_key k;
        k.len = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(13);
        foreach (k.w[i]) k.w[i] = $urandom;
        return k;
    endfunction

    task automatic noise_word();
        t_in_word w;
        w = t_in_word'({$urandom, $urandom});
        send_word(w);
    endtask

    initial begin
        t_key     k;
        t_in_word w;
        logic [31:0] cell_set [6] = '{32'd65536, 32'd1, 32'd100, 32'd0, 32'h1ffff, 32'd4093};
        logic [31:0] hash_set [6] = '{32'd8, 32'd1, 32'd3, 32'd0, 32'd15, 32'd5};
        cycles   = 0;
        i_rst_n  = 1'b0;
        start    = 1'b0;
        i_in     = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        idle_pct = 0;
        words_sent = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset registers, field extremes, odd word shapes
        k.len = 0;
        foreach (k.w[i]) k.w[i] = 32'hffffffff;
        send_key(k, KIND_QUERY);
        send_key(k, KIND_INSERT);
        send_key(k, KIND_QUERY);
        k.len = 4;
        k.w[0] = 32'h0;
        send_key(k, KIND_INSERT);
        send_key(k, KIND_QUERY);
        for (int vb = 0; vb < 8; vb++) begin
            w.kind = 1'($urandom); w.key_word = 32'hffffffff; w.valid_bytes = 3'(vb);
            w.key_length = 8'd255; w.last = 1'b0;
            send_word(w);
        end
        w.last = 1'b1; w.kind = KIND_QUERY; w.valid_bytes = 3'd7; w.key_word = 32'h0;
        send_word(w);
        k.len = 255;
        foreach (k.w[i]) k.w[i] = $urandom;
        send_key(k, KIND_INSERT);
        send_key(k, KIND_QUERY);
        settle_and_configure(32'd0, 32'd0);
        send_key(k, KIND_INSERT);
        send_key(k, KIND_QUERY);
        settle_and_configure(32'h1ffff, 32'd15);
        send_key(k, KIND_QUERY);

        foreach (key_pool[i]) key_pool[i] = random_key();
        for (int seg = 0; seg < 6; seg++) begin
            settle_and_configure(cell_set[seg], hash_set[seg]);
            idle_pct = (seg < 2) ? 10 : (seg < 4) ? 62 : 0;
            while (words_sent < 25 + (seg + 1) * 330) begin
                case ($urandom_range(9))
                    0: noise_word();
                    1, 2, 3: begin
                        k = random_key();
                        send_key(k, 1'($urandom));
                        key_pool[$urandom_range(15)] = k;
                    end
                    4, 5: send_key(key_pool[$urandom_range(15)], KIND_INSERT);
                    default: send_key(key_pool[$urandom_range(15)], KIND_QUERY);
                endcase
            end
        end
        // close any key left open by noise
        w = t_in_word'({$urandom, $urandom});
        w.last = 1'b1;
        send_word(w);

        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        $display("sent %0d words over six register settings, %0d results checked",
                 words_sent, results);
        $display("%0d queries found their key present", hits);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> bloom_filter_murmur2.f
hdl/bfm2_pkg.sv
hdl/bfm2_ram.sv
hdl/bloom_filter_murmur2.sv
tb/sv/bfm2_checker.sv
tb/sv/bloom_filter_murmur2_tb.sv
